>>> sv/flsf_pkg.sv
// shared constants for the frequency level step finder
package flsf_pkg;

  localparam int MAX_LEVELS_DEF = 32;
  localparam int NUM_CLUSTERS   = 3;

  localparam int VALUE_W = 32;
  localparam int LEVEL_W = 6;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 5;
  localparam int CPU_W   = 4;
  localparam int ADDR_W  = 4;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FIND  = 2'd1,
    OP_CROSS = 2'd2
  } op_t;

  localparam logic [1:0] REG_LEVELS_ZERO = 2'd0;
  localparam logic [1:0] REG_LEVELS_ONE  = 2'd1;
  localparam logic [1:0] REG_LEVELS_TWO  = 2'd2;

  localparam logic [1:0] CLUSTER_ZERO = 2'd0;
  localparam logic [1:0] CLUSTER_ONE  = 2'd1;
  localparam logic [1:0] CLUSTER_TWO  = 2'd2;

  localparam logic [CPU_W-1:0] CPU_LAST_ZERO = 4'd3;
  localparam logic [CPU_W-1:0] CPU_LAST_ONE  = 4'd6;
  localparam logic [CPU_W-1:0] CPU_LAST_TWO  = 4'd7;

endpackage

>>> sv/freq_level_step_finder.sv
// Frequency level step finder: one value table per CPU cluster in a single
// synchronous RAM, walked by a small sequencer. A load goes straight to the
// done state, a cross check reads two entries and compares them, and a find
// walks from the target toward entry zero or the top entry (the last table
// index in use for the cluster). The walk reads one table entry per cycle
// through the single read port. One transaction is worked on at a time; the
// next is accepted in the cycle after the result is loaded into the output
// register, even if the consumer has not taken it yet. A result waits in the
// done state while the output register is full. Table contents are undefined
// until loaded.
module freq_level_step_finder #(
  parameter int MAX_LEVELS = flsf_pkg::MAX_LEVELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_operation,
  input  logic [flsf_pkg::CPU_W-1:0]           in_cpu,
  input  logic signed [flsf_pkg::INDEX_W-1:0]  in_target_index,
  input  logic signed [flsf_pkg::INDEX_W-1:0]  in_prefer_index,
  input  logic                                 in_ascending,
  input  logic [flsf_pkg::COUNT_W-1:0]         in_level_count,
  input  logic [1:0]                           in_load_cluster,
  input  logic [4:0]                           in_load_index,
  input  logic [flsf_pkg::VALUE_W-1:0]         in_load_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [flsf_pkg::INDEX_W-1:0]  out_result_index,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [flsf_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int IW    = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;
  localparam int DEPTH = flsf_pkg::NUM_CLUSTERS * MAX_LEVELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = 10;
  localparam logic [NW-1:0] MAX_V = NW'(MAX_LEVELS);
  localparam int LW    = flsf_pkg::LEVEL_W;
  localparam int XW    = flsf_pkg::INDEX_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD0  = 6'b000010,
    S_RD1  = 6'b000100,
    S_WALK = 6'b001000,
    S_CMP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // configuration registers
  logic [LW-1:0] levels_r [flsf_pkg::NUM_CLUSTERS];
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  // table memory
  logic [flsf_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [flsf_pkg::VALUE_W-1:0] rdata_r;
  logic [AW-1:0]                raddr;
  logic [AW-1:0]                waddr;
  logic                         mem_we;
  logic [IW-1:0]                rd_idx;

  // sequencer state
  state_t                state_r, state_nxt;
  logic                  is_find_r, is_find_nxt;
  logic                  asc_r, asc_nxt;
  logic [1:0]            cl_r, cl_nxt;
  logic [IW-1:0]         top_r, top_nxt;
  logic [IW-1:0]         a_r, a_nxt;
  logic [IW-1:0]         b_r, b_nxt;
  logic [IW-1:0]         pre_r, pre_nxt;
  logic [IW-1:0]         pref_r, pref_nxt;
  logic [flsf_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [flsf_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [XW-1:0]         tgt_r, tgt_nxt;
  logic [XW-1:0]         prf_r, prf_nxt;
  logic [XW-1:0]         res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [XW-1:0]         out_res_r, out_res_nxt;

  // decode of the incoming transaction
  logic          in_acc;
  logic [1:0]    cl_c;
  logic          cl_ok;
  logic [NW-1:0] lim_c, top10_c, t10, p10;
  logic          t_neg, p_neg, t_in, p_in;
  logic          find_triv, cross_triv;
  logic [IW-1:0] t_ix, p_ix, top_c;
  logic [NW-1:0] li10;
  logic          load_ok;

  // walk step
  logic          at_end, changed, walk_done;
  logic [IW-1:0] pre_step;
  logic [NW-1:0] pre10, pref10, top10_r;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // apb
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      flsf_pkg::REG_LEVELS_ZERO: prdata = 32'(levels_r[0]);
      flsf_pkg::REG_LEVELS_ONE:  prdata = 32'(levels_r[1]);
      flsf_pkg::REG_LEVELS_TWO:  prdata = 32'(levels_r[2]);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < flsf_pkg::NUM_CLUSTERS; i++) begin
        levels_r[i] <= LW'(1);
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        flsf_pkg::REG_LEVELS_ZERO: levels_r[0] <= pwdata[LW-1:0];
        flsf_pkg::REG_LEVELS_ONE:  levels_r[1] <= pwdata[LW-1:0];
        flsf_pkg::REG_LEVELS_TWO:  levels_r[2] <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // cluster of the cpu and its last table index
  always_comb begin
    cl_ok = 1'b1;
    priority if (in_cpu <= flsf_pkg::CPU_LAST_ZERO) begin
      cl_c = flsf_pkg::CLUSTER_ZERO;
    end else if (in_cpu <= flsf_pkg::CPU_LAST_ONE) begin
      cl_c = flsf_pkg::CLUSTER_ONE;
    end else if (in_cpu == flsf_pkg::CPU_LAST_TWO) begin
      cl_c = flsf_pkg::CLUSTER_TWO;
    end else begin
      cl_c  = flsf_pkg::CLUSTER_ZERO;
      cl_ok = 1'b0;
    end
  end

  always_comb begin
    priority if (levels_r[cl_c] == '0) begin
      lim_c = NW'(1);
    end else if (NW'(levels_r[cl_c]) > MAX_V) begin
      lim_c = MAX_V;
    end else begin
      lim_c = NW'(levels_r[cl_c]);
    end
  end

  assign top10_c = lim_c - NW'(1);
  assign top_c   = top10_c[IW-1:0];
  assign t_neg   = in_target_index[XW-1];
  assign p_neg   = in_prefer_index[XW-1];
  assign t10     = NW'(in_target_index[XW-2:0]);
  assign p10     = NW'(in_prefer_index[XW-2:0]);
  assign t_ix    = t10[IW-1:0];
  assign p_ix    = p10[IW-1:0];
  assign t_in    = !t_neg && (t10 <= top10_c);
  assign p_in    = !p_neg && (p10 <= top10_c);

  assign find_triv = !cl_ok || !t_in || (in_level_count == '0) ||
                     (in_ascending ? (t10 == '0) : (t10 == top10_c));
  assign cross_triv = !cl_ok ||
                      (in_ascending ? (t_neg || t10 == '0 || t10 > top10_c)
                                    : (t_neg || t10 >= top10_c)) ||
                      (in_target_index == in_prefer_index) || !p_in;

  assign li10    = NW'(in_load_index);
  assign load_ok = (in_load_cluster != 2'd3) && (li10 < MAX_V);
  assign mem_we  = in_acc && (in_operation == flsf_pkg::OP_LOAD) && load_ok;
  assign waddr   = AW'(in_load_cluster) * AW'(MAX_LEVELS) + AW'(li10[IW-1:0]);

  // walk step on the entry read last cycle
  assign pre_step  = asc_r ? (pre_r - IW'(1)) : (pre_r + IW'(1));
  assign at_end    = asc_r ? (pre_r == '0) : (pre_r == top_r);
  assign changed   = (val_r != rdata_r);
  assign walk_done = at_end || (changed && cnt_r == flsf_pkg::COUNT_W'(1));
  assign pre10     = NW'(pre_r);
  assign pref10    = NW'(pref_r);
  assign top10_r   = NW'(top_r);

  always_comb begin
    unique case (state_r)
      S_RD0:   rd_idx = a_r;
      S_RD1:   rd_idx = is_find_r ? pre_r : b_r;
      S_WALK:  rd_idx = walk_done ? pre_r : pre_step;
      default: rd_idx = a_r;
    endcase
  end

  assign raddr = AW'(cl_r) * AW'(MAX_LEVELS) + AW'(rd_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_load_value;
    end
    rdata_r <= mem[raddr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    is_find_nxt   = is_find_r;
    asc_nxt       = asc_r;
    cl_nxt        = cl_r;
    top_nxt       = top_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    pre_nxt       = pre_r;
    pref_nxt      = pref_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    tgt_nxt       = tgt_r;
    prf_nxt       = prf_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          is_find_nxt = (in_operation == flsf_pkg::OP_FIND);
          asc_nxt     = in_ascending;
          cl_nxt      = cl_c;
          top_nxt     = top_c;
          tgt_nxt     = in_target_index;
          prf_nxt     = in_prefer_index;
          cnt_nxt     = in_level_count;
          pref_nxt    = t_ix;
          res_nxt     = in_target_index;
          state_nxt   = S_DONE;
          unique case (in_operation)
            flsf_pkg::OP_LOAD: begin
              res_nxt = '0;
            end
            flsf_pkg::OP_FIND: begin
              a_nxt   = t_ix;
              pre_nxt = in_ascending ? (t_ix - IW'(1)) : (t_ix + IW'(1));
              if (!find_triv) begin
                state_nxt = S_RD0;
              end
            end
            flsf_pkg::OP_CROSS: begin
              // descending mode mirrors both indices about the top entry
              a_nxt = in_ascending ? t_ix : (top_c - t_ix);
              b_nxt = in_ascending ? p_ix : (top_c - p_ix);
              if (!cross_triv) begin
                state_nxt = S_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        val_nxt   = rdata_r;
        state_nxt = is_find_r ? S_WALK : S_CMP;
      end
      S_WALK: begin
        if (at_end) begin
          if (val_r == rdata_r) begin
            res_nxt = pref10[XW-1:0];
          end else begin
            res_nxt = asc_r ? '0 : top10_r[XW-1:0];
          end
          state_nxt = S_DONE;
        end else begin
          if (changed) begin
            val_nxt  = rdata_r;
            pref_nxt = pre_r;
            cnt_nxt  = cnt_r - flsf_pkg::COUNT_W'(1);
          end
          if (walk_done) begin
            res_nxt   = pre10[XW-1:0];
            state_nxt = S_DONE;
          end else begin
            pre_nxt = pre_step;
          end
        end
      end
      S_CMP: begin
        res_nxt   = (val_r == rdata_r) ? tgt_r : prf_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_find_r <= is_find_nxt;
    asc_r     <= asc_nxt;
    cl_r      <= cl_nxt;
    top_r     <= top_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    pre_r     <= pre_nxt;
    pref_r    <= pref_nxt;
    cnt_r     <= cnt_nxt;
    val_r     <= val_nxt;
    tgt_r     <= tgt_nxt;
    prf_r     <= prf_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_res_r;

endmodule

>>> tb/sv/testbench.sv
// testbench for the frequency level step finder: directed and random traffic against a predictor
`timescale 1ns / 100ps

module testbench;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int DRAIN_CYCLES    = 48;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 105;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam logic [1:0] CLUSTER_NONE = 2'd3;

  typedef struct {
    logic [1:0]                          op;
    logic [flsf_pkg::CPU_W-1:0]          cpu;
    logic signed [flsf_pkg::INDEX_W-1:0] target;
    logic signed [flsf_pkg::INDEX_W-1:0] prefer;
    logic                                asc;
    logic [flsf_pkg::COUNT_W-1:0]        count;
    logic [1:0]                          lcluster;
    logic [4:0]                          lindex;
    logic [flsf_pkg::VALUE_W-1:0]        lvalue;
  } level_req_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [1:0]                          in_operation = '0;
  logic [flsf_pkg::CPU_W-1:0]          in_cpu = '0;
  logic signed [flsf_pkg::INDEX_W-1:0] in_target_index = '0;
  logic signed [flsf_pkg::INDEX_W-1:0] in_prefer_index = '0;
  logic                                in_ascending = 1'b0;
  logic [flsf_pkg::COUNT_W-1:0]        in_level_count = '0;
  logic [1:0]                          in_load_cluster = '0;
  logic [4:0]                          in_load_index = '0;
  logic [flsf_pkg::VALUE_W-1:0]        in_load_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [flsf_pkg::INDEX_W-1:0] out_result_index;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [flsf_pkg::ADDR_W-1:0]         paddr = '0;
  logic [31:0]                         pwdata = '0;
  logic [31:0]                         prdata;
  logic                                pready;

  // predictor state
  logic [flsf_pkg::VALUE_W-1:0] level_table [flsf_pkg::NUM_CLUSTERS][flsf_pkg::MAX_LEVELS_DEF];
  logic [flsf_pkg::LEVEL_W-1:0] level_reg [flsf_pkg::NUM_CLUSTERS];

  logic [flsf_pkg::INDEX_W-1:0] expected_index [$];
  int                           errors = 0;
  int                           cycles = 0;
  bit                           send_gaps = 1'b1;
  bit                           sink_stalls = 1'b1;

  freq_level_step_finder #(
    .MAX_LEVELS(flsf_pkg::MAX_LEVELS_DEF)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_cpu          (in_cpu),
    .in_target_index (in_target_index),
    .in_prefer_index (in_prefer_index),
    .in_ascending    (in_ascending),
    .in_level_count  (in_level_count),
    .in_load_cluster (in_load_cluster),
    .in_load_index   (in_load_index),
    .in_load_value   (in_load_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_index(out_result_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               expected_index.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int cluster_for_cpu(logic [flsf_pkg::CPU_W-1:0] cpu);
    if (cpu <= flsf_pkg::CPU_LAST_ZERO) return flsf_pkg::CLUSTER_ZERO;
    if (cpu <= flsf_pkg::CPU_LAST_ONE) return flsf_pkg::CLUSTER_ONE;
    if (cpu == flsf_pkg::CPU_LAST_TWO) return flsf_pkg::CLUSTER_TWO;
    return -1;
  endfunction

  function automatic int last_entry(int cl);
    int n;
    n = level_reg[cl];
    if (n < 1) n = 1;
    if (n > flsf_pkg::MAX_LEVELS_DEF) n = flsf_pkg::MAX_LEVELS_DEF;
    return n - 1;
  endfunction

  // walk from the target, counting changes of table value, stop at the table end
  function automatic int step_levels(int cl, int t, logic asc, int cnt);
    int top, pref, pos;
    logic [flsf_pkg::VALUE_W-1:0] cur;
    top = last_entry(cl);
    pref = t;
    if (t < 0 || t > top) return t;
    if (asc) begin
      if (t == 0 || cnt == 0) return t;
      pos = t - 1;
      cur = level_table[cl][t];
      while (cnt > 0) begin
        if (pos == 0) return (cur == level_table[cl][0]) ? pref : 0;
        if (cur != level_table[cl][pos]) begin
          cur = level_table[cl][pos];
          pref = pos;
          cnt--;
        end
        pos--;
      end
    end else begin
      if (t == top || cnt == 0) return t;
      pos = t + 1;
      cur = level_table[cl][t];
      while (cnt > 0) begin
        if (pos == top) return (cur == level_table[cl][top]) ? pref : top;
        if (cur != level_table[cl][pos]) begin
          cur = level_table[cl][pos];
          pref = pos;
          cnt--;
        end
        pos++;
      end
    end
    return pref;
  endfunction

  // descending mode compares mirrored entries
  function automatic int cross_pick(int cl, int p, int t, logic asc);
    int top;
    top = last_entry(cl);
    if (asc && (t <= 0 || t > top)) return t;
    if (!asc && (t < 0 || t >= top)) return t;
    if (t == p) return t;
    if (p < 0 || p > top) return t;
    if (asc) begin
      if (level_table[cl][t] == level_table[cl][p]) return t;
    end else begin
      if (level_table[cl][top - t] == level_table[cl][top - p]) return t;
    end
    return p;
  endfunction

  function automatic logic [flsf_pkg::INDEX_W-1:0] predict_level_index(level_req_t r);
    int cl, res;
    cl = cluster_for_cpu(r.cpu);
    res = r.target;
    case (r.op)
      flsf_pkg::OP_LOAD: begin
        if (r.lcluster != CLUSTER_NONE) level_table[r.lcluster][r.lindex] = r.lvalue;
        res = 0;
      end
      flsf_pkg::OP_FIND: begin
        if (cl >= 0) res = step_levels(cl, r.target, r.asc, r.count);
      end
      flsf_pkg::OP_CROSS: begin
        if (cl >= 0) res = cross_pick(cl, r.prefer, r.target, r.asc);
      end
      default: ;
    endcase
    return flsf_pkg::INDEX_W'(res);
  endfunction

  // ---------------------------------------------------------------- requests

  function automatic level_req_t make_req(logic [1:0] op, logic [flsf_pkg::CPU_W-1:0] cpu,
                                          int t, int p, logic asc, int cnt);
    level_req_t r;
    r.op = op;
    r.cpu = cpu;
    r.target = flsf_pkg::INDEX_W'(t);
    r.prefer = flsf_pkg::INDEX_W'(p);
    r.asc = asc;
    r.count = flsf_pkg::COUNT_W'(cnt);
    r.lcluster = 2'($urandom_range(0, 3));
    r.lindex = 5'($urandom);
    r.lvalue = $urandom;
    return r;
  endfunction

  function automatic level_req_t load_req(logic [1:0] cl, int idx,
                                          logic [flsf_pkg::VALUE_W-1:0] value);
    level_req_t r;
    r = make_req(flsf_pkg::OP_LOAD, flsf_pkg::CPU_W'($urandom), $urandom, $urandom,
                 1'($urandom), $urandom);
    r.lcluster = cl;
    r.lindex = 5'(idx);
    r.lvalue = value;
    return r;
  endfunction

  // mostly well-formed finds and cross checks on the active table, some reloads, some noise
  function automatic level_req_t random_request();
    level_req_t r;
    int pick, cl, top;
    r = make_req(2'($urandom_range(0, 2)), flsf_pkg::CPU_W'($urandom_range(0, 7)), $urandom,
                 $urandom, 1'($urandom), $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      r.op = flsf_pkg::OP_LOAD;
      r.lcluster = (pick == 0) ? CLUSTER_NONE : 2'($urandom_range(0, 2));
      // copying a neighbor keeps runs of equal values in the table
      if (r.lcluster != CLUSTER_NONE && $urandom_range(0, 1) == 1)
        r.lvalue = level_table[r.lcluster][(r.lindex == 0) ? 5'd1 : r.lindex - 5'd1];
    end else if (pick < 88) begin
      r.op = (pick < 52) ? flsf_pkg::OP_FIND : flsf_pkg::OP_CROSS;
      cl = cluster_for_cpu(r.cpu);
      top = last_entry(cl);
      r.target = flsf_pkg::INDEX_W'($urandom_range(0, top));
      if ($urandom_range(0, 4) != 0) r.prefer = flsf_pkg::INDEX_W'($urandom_range(0, top));
      if ($urandom_range(0, 7) != 0) r.count = flsf_pkg::COUNT_W'($urandom_range(1, 4));
    end else begin
      r.op = 2'($urandom_range(0, 3));
      r.cpu = flsf_pkg::CPU_W'($urandom);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- channels

  task automatic send_item(level_req_t r);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= r.op;
    in_cpu          <= r.cpu;
    in_target_index <= r.target;
    in_prefer_index <= r.prefer;
    in_ascending    <= r.asc;
    in_level_count  <= r.count;
    in_load_cluster <= r.lcluster;
    in_load_index   <= r.lindex;
    in_load_value   <= r.lvalue;
    do @(posedge clk); while (!in_ready);
    expected_index.push_back(predict_level_index(r));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_index.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    logic [flsf_pkg::INDEX_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_index.size() == 0) begin
        $display("%0t: result_index expected none actual %0d", $time, out_result_index);
        errors++;
      end else begin
        want = expected_index.pop_front();
        if (out_result_index !== want) begin
          $display("%0t: result_index expected %0d actual %0d", $time, $signed(want),
                   out_result_index);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- registers

  task automatic cfg_access(logic wr, logic [1:0] idx, logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && idx <= flsf_pkg::REG_LEVELS_TWO) level_reg[idx] = data[flsf_pkg::LEVEL_W-1:0];
  endtask

  task automatic check_levels();
    logic [31:0] rd;
    for (int i = flsf_pkg::REG_LEVELS_ZERO; i <= flsf_pkg::REG_LEVELS_TWO; i++) begin
      cfg_access(1'b0, 2'(i), '0, rd);
      if (rd !== 32'(level_reg[i])) begin
        $display("%0t: level register %0d expected %0d actual %0d", $time, i, level_reg[i], rd);
        errors++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_levels(int zero, int one, int two);
    logic [31:0] rd;
    wait_for_results();
    cfg_access(1'b1, flsf_pkg::REG_LEVELS_ZERO, 32'(zero), rd);
    cfg_access(1'b1, flsf_pkg::REG_LEVELS_ONE, 32'(one), rd);
    cfg_access(1'b1, flsf_pkg::REG_LEVELS_TWO, 32'(two), rd);
    // unmapped slot, must not disturb anything
    cfg_access(1'b1, REG_UNMAPPED, $urandom, rd);
    check_levels();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic load_all_tables();
    logic [flsf_pkg::VALUE_W-1:0] v;
    for (int c = flsf_pkg::CLUSTER_ZERO; c <= flsf_pkg::CLUSTER_TWO; c++) begin
      for (int i = 0; i < flsf_pkg::MAX_LEVELS_DEF; i++) begin
        v = $urandom;
        if (i > 0 && $urandom_range(0, 2) == 0) v = level_table[c][i - 1];
        send_item(load_req(2'(c), i, v));
      end
    end
  endtask

  task automatic test_loads_and_unused();
    send_item(load_req(flsf_pkg::CLUSTER_ZERO, 0, '0));
    send_item(load_req(flsf_pkg::CLUSTER_TWO, flsf_pkg::MAX_LEVELS_DEF - 1, '1));
    send_item(load_req(CLUSTER_NONE, flsf_pkg::MAX_LEVELS_DEF - 1, $urandom));
    send_item(make_req(OP_UNUSED, 4'd2, -5, 9, 1'b1, 3));
  endtask

  // cluster zero has 32 levels, cluster one a single level, cluster two a clamped count
  task automatic test_find_edges();
    send_item(make_req(flsf_pkg::OP_FIND, 4'd0, 31, 0, 1'b1, 1));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd1, 31, 0, 1'b1, 31));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd2, 0, 0, 1'b1, 3));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd3, 0, 0, 1'b0, 31));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd0, 31, 0, 1'b0, 2));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd0, 10, 0, 1'b1, 0));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd0, -1, 0, 1'b1, 2));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd0, 63, 0, 1'b0, 2));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd8, 5, 0, 1'b1, 2));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd15, 5, 0, 1'b0, 2));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd4, 0, 0, 1'b0, 1));
    send_item(make_req(flsf_pkg::OP_FIND, 4'd7, 5, 0, 1'b0, 2));
  endtask

  task automatic test_cross_edges();
    logic [flsf_pkg::VALUE_W-1:0] v;
    v = $urandom;
    send_item(load_req(flsf_pkg::CLUSTER_ZERO, 10, v));
    send_item(load_req(flsf_pkg::CLUSTER_ZERO, 11, v));
    send_item(make_req(flsf_pkg::OP_CROSS, 4'd0, 11, 10, 1'b1, 0));
    // mirrored: entries 11 and 10 again
    send_item(make_req(flsf_pkg::OP_CROSS, 4'd1, 20, 21, 1'b0, 0));
    send_item(make_req(flsf_pkg::OP_CROSS, 4'd3, 7, 7, 1'b1, 0));
    send_item(make_req(flsf_pkg::OP_CROSS, 4'd0, 5, -64, 1'b1, 0));
    send_item(make_req(flsf_pkg::OP_CROSS, 4'd2, 5, 63, 1'b0, 0));
    send_item(make_req(flsf_pkg::OP_CROSS, 4'd0, 0, 3, 1'b1, 0));
    send_item(make_req(flsf_pkg::OP_CROSS, 4'd0, 31, 3, 1'b0, 0));
    send_item(make_req(flsf_pkg::OP_CROSS, 4'd6, 0, 0, 1'b1, 0));
    send_item(make_req(flsf_pkg::OP_CROSS, 4'd7, 5, 4, 1'b1, 0));
  endtask

  task automatic test_random_traffic();
    int zero, one, two;
    bit quiet;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          zero = flsf_pkg::MAX_LEVELS_DEF;
          one = flsf_pkg::MAX_LEVELS_DEF;
          two = flsf_pkg::MAX_LEVELS_DEF;
        end
        1: begin zero = 1; one = 1; two = 1; end
        2: begin zero = 0; one = 63; two = 2; end
        default: begin
          zero = $urandom_range(0, 63);
          one = $urandom_range(1, flsf_pkg::MAX_LEVELS_DEF);
          two = $urandom_range(1, flsf_pkg::MAX_LEVELS_DEF);
        end
      endcase
      set_levels(zero, one, two);
      quiet = (ph == RANDOM_PHASES - 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_gaps = !quiet && ((k / 30) % 3 != 2);
        sink_stalls = !quiet && ((k / 20) % 3 != 1);
        // let the pipeline empty completely in mid-phase
        if (ph == 1 && k == ITEMS_PER_PHASE / 2) wait_for_results();
        send_item(random_request());
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < flsf_pkg::NUM_CLUSTERS; i++) level_reg[i] = flsf_pkg::LEVEL_W'(1);
    check_levels();
    load_all_tables();
    set_levels(flsf_pkg::MAX_LEVELS_DEF, 0, 63);
    test_loads_and_unused();
    test_find_edges();
    test_cross_edges();
    test_random_traffic();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
